[rtl/ase_pkg.sv]
// Package for the array stack engine: operation and error codes, field widths, cell control.
package ase_pkg;

  localparam int OpW   = 2;
  localparam int WordW = 32;
  localparam int IdxW  = 7;
  localparam int CapW  = 7;
  localparam int ErrW  = 2;

  localparam logic [OpW-1:0] OP_PUSH = 2'd0;
  localparam logic [OpW-1:0] OP_POP  = 2'd1;
  localparam logic [OpW-1:0] OP_PEEK = 2'd2;

  localparam logic [ErrW-1:0] ERR_OK        = 2'd0;
  localparam logic [ErrW-1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [ErrW-1:0] ERR_UNDERFLOW = 2'd2;
  localparam logic [ErrW-1:0] ERR_INDEX     = 2'd3;

  localparam logic [CapW-1:0] CAP_RESET = 7'd64;

  // packed payload widths, padded to whole bytes
  localparam int InBits   = OpW + WordW + IdxW;
  localparam int InDataW  = ((InBits + 7) / 8) * 8;
  localparam int OutBits  = WordW + ErrW + WordW + 2;
  localparam int OutDataW = ((OutBits + 7) / 8) * 8;

  // control broadcast to every stack cell
  typedef struct packed {
    logic push;   // shift entries one place down, push word into the top cell
    logic pop;    // shift entries one place up
    logic load;   // copy entries into the peek shadow row
    logic walk;   // shift the shadow row one place up
  } ase_ctl_t;

endpackage

[rtl/ase_cell.sv]
// One stack cell: an entry register and a shadow register for peek walks.
module ase_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  ase_pkg::ase_ctl_t     ctl,
  input  logic [DATA_WIDTH-1:0] ent_above,
  input  logic [DATA_WIDTH-1:0] ent_below,
  input  logic [DATA_WIDTH-1:0] shd_below,
  output logic [DATA_WIDTH-1:0] ent_q,
  output logic [DATA_WIDTH-1:0] shd_q
);
  import ase_pkg::*;

  logic [DATA_WIDTH-1:0] ent_r;
  logic [DATA_WIDTH-1:0] shd_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ent_r <= ent_above;
    end else if (ctl.pop) begin
      ent_r <= ent_below;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      shd_r <= ent_r;
    end else if (ctl.walk) begin
      shd_r <= shd_below;
    end
  end

  assign ent_q = ent_r;
  assign shd_q = shd_r;

endmodule

[rtl/array_stack_engine.sv]
// Top level of the array stack engine: bounded LIFO built as a shifting row of cells.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in_     | slave     | in_tvalid/in_tready | in_tdata: operation, push_value, peek_index
//  out_    | master    | out_tvalid/tready   | out_tdata: data_word, error_code, top_word,
//          |           |                     |            full_flag, empty_flag
//  cfg_    | write     | cfg_wr_en           | cfg_wr_data: stack_capacity
//
// Push, pop, invalid peek and the unused code load their result into the output register
// on the cycle after the transaction. A valid peek of index k walks the shadow row of cells
// up k-1 places, one per cycle, then loads its result into the output register; input is
// blocked until that result is loaded.
// Reset (rst_n low, synchronous) clears the entry count, the capacity to 64 and the output
// valid; cell contents are not reset. A stalled result is held; a new transaction is taken
// in the same cycle the held result leaves.
module array_stack_engine #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // operation[1:0], push_value[33:2], peek_index[40:34], zero fill above
  input  logic [ase_pkg::InDataW-1:0]   in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // data_word[31:0], error_code[33:32], top_word[65:34], full_flag[66], empty_flag[67]
  output logic [ase_pkg::OutDataW-1:0]  out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_wr_en,
  input  logic [ase_pkg::CapW-1:0]      cfg_wr_data
);
  import ase_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);            // entry count width
  localparam int WW = (CW > IdxW) ? CW : IdxW;      // compare width
  localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_PEEK = 1'b1;

  // sign-extend or trim a stored word to the 32-bit result field
  function automatic logic [WordW-1:0] to_word(input logic [DATA_WIDTH-1:0] v);
    logic [63:0] ext;
    ext = 64'(signed'(v));
    return ext[WordW-1:0];
  endfunction

  // input field unpacking
  logic [OpW-1:0]   in_op;
  logic [WordW-1:0] in_pv;
  logic [IdxW-1:0]  in_idx;
  assign in_op  = in_tdata[OpW-1:0];
  assign in_pv  = in_tdata[OpW+WordW-1:OpW];
  assign in_idx = in_tdata[OpW+WordW+IdxW-1:OpW+WordW];

  logic            state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CapW-1:0] cap_r;
  logic [CW-1:0]   walk_r, walk_nxt;
  logic            out_valid_r;
  logic [WordW-1:0] o_data_r, o_top_r;
  logic [ErrW-1:0]  o_err_r;
  logic             o_full_r, o_empty_r;

  // cell row; index 0 is the top of stack, index DEPTH is a tie-off below the last cell
  logic [DATA_WIDTH-1:0] ent [DEPTH+1];
  logic [DATA_WIDTH-1:0] shd [DEPTH+1];
  ase_ctl_t              ctl;

  assign ent[DEPTH] = '0;
  assign shd[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ase_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .ent_above ((i == 0) ? DATA_WIDTH'(in_pv) : ent[(i == 0) ? 0 : i-1]),
      .ent_below (ent[i+1]),
      .shd_below (shd[i+1]),
      .ent_q     (ent[i]),
      .shd_q     (shd[i])
    );
  end

  // effective capacity: zero acts as one, clamped to DEPTH
  logic [WW-1:0] cap_raw, cap_eff, cnt_w, cnt_nxt_w, idx_w, idx_m1;
  assign cap_raw = WW'(cap_r);
  assign cap_eff = (cap_raw == '0) ? WW'(1) : ((cap_raw > DEPTH_W) ? DEPTH_W : cap_raw);
  assign cnt_w   = WW'(count_r);
  assign idx_w   = WW'(in_idx);
  assign idx_m1  = idx_w - WW'(1);

  logic in_fire, peek_go, peek_done, ld_out;
  logic [WordW-1:0] top_now, r_data, r_top;
  logic [ErrW-1:0]  r_err;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign top_now   = (count_r == '0) ? '1 : to_word(ent[0]);
  assign peek_done = (state_r == S_PEEK) && (walk_r == '0);

  always_comb begin
    ctl       = '0;
    count_nxt = count_r;
    state_nxt = state_r;
    walk_nxt  = walk_r;
    peek_go   = 1'b0;
    r_data    = '1;
    r_err     = ERR_OK;
    r_top     = top_now;
    if (in_fire) begin
      unique case (in_op)
        OP_PUSH: begin
          if (cnt_w >= cap_eff) begin
            r_err = ERR_OVERFLOW;
          end else begin
            ctl.push  = 1'b1;
            count_nxt = count_r + CW'(1);
            r_top     = to_word(DATA_WIDTH'(in_pv));
          end
        end
        OP_POP: begin
          if (count_r == '0) begin
            r_err = ERR_UNDERFLOW;
          end else begin
            ctl.pop   = 1'b1;
            count_nxt = count_r - CW'(1);
            r_data    = to_word(ent[0]);
            r_top     = (count_r > CW'(1)) ? to_word(ent[1]) : '1;
          end
        end
        OP_PEEK: begin
          if (idx_w == '0 || idx_w > cnt_w) begin
            r_err = ERR_INDEX;
          end else begin
            peek_go   = 1'b1;
            ctl.load  = 1'b1;
            walk_nxt  = idx_m1[CW-1:0];
            state_nxt = S_PEEK;
          end
        end
        default: begin
        end
      endcase
    end else if (state_r == S_PEEK) begin
      if (walk_r == '0) begin
        r_data    = to_word(shd[0]);
        state_nxt = S_IDLE;
      end else begin
        ctl.walk = 1'b1;
        walk_nxt = walk_r - CW'(1);
      end
    end
  end

  assign ld_out    = (in_fire && !peek_go) || peek_done;
  assign cnt_nxt_w = WW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      walk_r  <= walk_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload; count is unchanged during a peek walk
  always_ff @(posedge clk) begin
    if (ld_out) begin
      o_data_r  <= r_data;
      o_err_r   <= r_err;
      o_top_r   <= r_top;
      o_full_r  <= (cnt_nxt_w >= cap_eff);
      o_empty_r <= (count_nxt == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OutDataW'({o_empty_r, o_full_r, o_top_r, o_err_r, o_data_r});

  // never more entries than cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(count_r) <= DEPTH_W)
    else $error("entry count beyond depth");

  // no result is shown while a peek walk is still running
  a_peek_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PEEK) |-> !out_valid_r)
    else $error("result valid during peek walk");

  // an accepted push that did not overflow grows the stack by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == OP_PUSH && cnt_w < cap_eff) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not store");

  // an empty stack reports an all-ones top word
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_empty_r) |-> (o_top_r == '1))
    else $error("empty stack with top word");

endmodule
